// ===== design/sorted_key_multiset_defines.svh =====
// Assertion macros shared by the checker of the sorted key multiset.
// No dependencies; the including scope must provide clk_i and rst_ni.
`ifndef SORTED_KEY_MULTISET_DEFINES_SVH
`define SORTED_KEY_MULTISET_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_key_multiset: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_key_multiset: next-cycle check failed");

`endif

// ===== design/skm_pkg.sv =====
// Package of the sorted key multiset: word types, codes and cell control.
// No dependencies.
package skm_pkg;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned StatusW = 2;
  localparam int unsigned EntryW  = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic            action;
    logic [KeyW-1:0] key;
  } skm_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [EntryW-1:0]  entry_count;
  } skm_out_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic            cmp;      // compare phase: latch ordering flags
    logic            cmp_ins;  // compare for an insert (strict) or a remove
    logic            ins;      // apply an insert: shift up
    logic            rem;      // apply a remove: shift down
    logic [KeyW-1:0] key;      // key of the operation in progress
  } skm_ctl_t;

endpackage

// ===== design/skm_cell.sv =====
// One storage cell of the sorted key chain: an entry, its ordering flags
// and the shift muxes to both neighbors. Depends on skm_pkg.
module skm_cell import skm_pkg::*; #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  skm_ctl_t         ctl_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [KeyW-1:0]  left_key_i,
  input  logic             left_ge_i,
  input  logic [KeyW-1:0]  right_key_i,
  output logic [KeyW-1:0]  key_o,
  output logic             ge_o,
  output logic             eq_o
);

  logic [KeyW-1:0] key_q;
  logic            ge_q;
  logic            eq_q;
  logic            occupied;

  assign occupied = CNT_W'(INDEX) < count_i;

  // The ge flag marks cells at or after the place where the chain changes.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      if (ctl_i.cmp_ins) begin
        ge_q <= !occupied || (key_q > ctl_i.key);
      end else begin
        ge_q <= !occupied || (key_q >= ctl_i.key);
      end
      eq_q <= occupied && (key_q == ctl_i.key);
    end else if (ctl_i.ins) begin
      if (left_ge_i) begin
        key_q <= left_key_i;
      end else if (ge_q) begin
        key_q <= ctl_i.key;
      end
    end else if (ctl_i.rem) begin
      if (ge_q) begin
        key_q <= right_key_i;
      end
    end
  end

  assign key_o = key_q;
  assign ge_o  = ge_q;
  assign eq_o  = eq_q;

endmodule

// ===== design/sorted_key_multiset.sv =====
// Top level of the sorted key multiset: sequencer, entry count and the
// chain of skm_cell storage cells. Depends on skm_pkg and skm_cell.
//
//   channel   direction  handshake                 word
//   command   in         start_i high, busy_o low  item_i   (skm_in_t)
//   result    out        done_o, one cycle         result_o (skm_out_t)
//
// An accepted word is handled in a compare step and then an apply step: in
// the compare step every cell compares its entry with the key and latches
// its ordering flags, in the apply step the flags of the whole chain are
// combined into found and the cells shift. busy_o is high in the apply step;
// the result is shown on the cycle after it, during which the next word may
// already be accepted. No new word is taken while busy_o is high.
// Reset clears the entry count and the sequencer; the entries need no reset.
// The receiver cannot stall: each result is valid for exactly one cycle.
module sorted_key_multiset import skm_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  skm_in_t  item_i,
  output logic     busy_o,
  output logic     done_o,
  output skm_out_t result_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             busy_q;
  logic             done_q;
  skm_in_t          cmd_q;
  skm_out_t         res_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;

  logic             accept;
  logic             full;
  logic             found;
  logic [StatusW-1:0] status_d;
  logic             do_ins;
  logic             do_rem;
  skm_ctl_t         ctl;
  logic [CNT_W+EntryW-1:0] count_ext;

  logic [KeyW-1:0]     cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_eq;

  assign accept = start_i && !busy_q;
  assign full   = (count_q == CNT_W'(CAPACITY));
  // An equal entry exists exactly when at least one cell matched.
  assign found  = |cell_eq;

  // Decide the outcome in the apply cycle.
  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    status_d = ST_DONE;
    count_d  = count_q;
    if (cmd_q.action == ACT_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        do_ins  = 1'b1;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (found) begin
        do_rem  = 1'b1;
        count_d = count_q - CNT_W'(1);
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end
  end

  // The key comes straight from the port while comparing, and from the
  // command register while the chain shifts.
  always_comb begin
    ctl.cmp     = accept;
    ctl.cmp_ins = (item_i.action == ACT_INSERT);
    ctl.ins     = busy_q && do_ins;
    ctl.rem     = busy_q && do_rem;
    ctl.key     = accept ? item_i.key : cmd_q.key;
  end

  // The entry count field is the count truncated or extended to its width.
  assign count_ext = {{EntryW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b1;
        count_q <= count_d;
      end else if (accept) begin
        busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i;
    end
    if (busy_q) begin
      res_q.status      <= status_d;
      res_q.entry_count <= count_ext[EntryW-1:0];
    end
  end

  // The chain: each cell sees the entry and flag of its lower neighbor for
  // inserts and the entry of its upper neighbor for removes.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyW-1:0] left_key;
    logic            left_ge;
    logic [KeyW-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_ge  = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    skm_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .left_key_i  (left_key),
      .left_ge_i   (left_ge),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .ge_o        (cell_ge[i]),
      .eq_o        (cell_eq[i])
    );
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== design/skm_checker.sv =====
// Port-level checker of the sorted key multiset and its bind statement.
// Depends on skm_pkg and sorted_key_multiset_defines.svh.
`include "sorted_key_multiset_defines.svh"

module skm_checker import skm_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input skm_in_t  item_i,
  input logic     busy_o,
  input logic     done_o,
  input skm_out_t result_o
);

  localparam logic [EntryW+15:0] CapWide = (EntryW + 16)'(CAPACITY);
  localparam logic [EntryW-1:0]  CapField = CapWide[EntryW-1:0];

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Each accepted word sets the block busy, then busy drops as it reports.
  `SKM_ASSERT_NEXT(a_accept_busy, accepted, busy_o)
  `SKM_ASSERT_NEXT(a_busy_done, busy_o, done_o && !busy_o)
  // A result only follows a busy cycle.
  `SKM_ASSERT_NOW(a_done_after_busy, done_o, $past(busy_o))
  // A refused insert reports a store filled to capacity.
  `SKM_ASSERT_NOW(a_full_count, done_o && (result_o.status == ST_FULL),
                  result_o.entry_count == CapField)

endmodule

bind sorted_key_multiset skm_checker #(.CAPACITY(CAPACITY)) u_skm_checker (.*);
